>>> hdl/ctu_pkg.sv
package ctu_pkg;

  localparam int unsigned CTU_ITERATIONS = 14;
  localparam int unsigned CTU_SQRT_STEPS = 15;

  localparam int unsigned CTU_XW = 19;
  localparam int unsigned CTU_ZW = 18;
  localparam int unsigned CTU_RW = 30;
  localparam int unsigned CTU_GW = 20;

  localparam logic [13:0] CTU_GAIN = 14'd9949;
  localparam logic signed [CTU_XW-1:0] CTU_ONE = 19'sd16384;
  localparam logic signed [CTU_GW-1:0] CTU_PI = 20'sd51472;

  typedef enum logic [1:0] {
    CTU_SINCOS = 2'd0,
    CTU_ATAN   = 2'd1,
    CTU_ACOS   = 2'd2,
    CTU_UNUSED = 2'd3
  } ctu_mode_e;

  typedef struct packed {
    ctu_mode_e                 mode;
    logic signed [15:0]        a;
    logic signed [15:0]        b;
    logic [14:0]               ap;
    logic                      neg;
    logic                      err;
    logic [CTU_RW-1:0]         r;
    logic [CTU_RW-1:0]         q;
    logic signed [CTU_XW-1:0]  x;
    logic signed [CTU_XW-1:0]  y;
    logic signed [CTU_ZW-1:0]  z;
  } ctu_word_t;

  typedef struct packed {
    ctu_mode_e                 mode;
    logic                      neg;
    logic                      err;
    logic signed [CTU_GW-1:0]  gx;
    logic signed [CTU_GW-1:0]  gy;
    logic signed [CTU_ZW-1:0]  z;
  } ctu_res_t;

  // round(atan(2^-i) * 2^14)
  function automatic logic [13:0] ctu_atan(input int unsigned i);
    logic [13:0] v;
    unique case (i)
      0:       v = 14'd12868;
      1:       v = 14'd7596;
      2:       v = 14'd4014;
      3:       v = 14'd2037;
      4:       v = 14'd1023;
      5:       v = 14'd512;
      6:       v = 14'd256;
      7:       v = 14'd128;
      8:       v = 14'd64;
      9:       v = 14'd32;
      10:      v = 14'd16;
      11:      v = 14'd8;
      12:      v = 14'd4;
      13:      v = 14'd2;
      14:      v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // convergence limit of the rotation: sum of the table entries in use
  function automatic int unsigned ctu_range(input int unsigned n);
    int unsigned s;
    s = 0;
    for (int unsigned k = 0; k < n; k++) s += ctu_atan(k);
    return s;
  endfunction

endpackage

>>> hdl/ctu_if.sv
interface ctu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] first_operand;
  logic signed [15:0] second_operand;

  modport source (output valid, mode, first_operand, second_operand, input ready);
  modport sink   (input valid, mode, first_operand, second_operand, output ready);
endinterface

interface ctu_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] angle_or_cosine;
  logic signed [15:0] sine_value;
  logic               domain_error;

  modport source (output valid, angle_or_cosine, sine_value, domain_error, input ready);
  modport sink   (input valid, angle_or_cosine, sine_value, domain_error, output ready);
endinterface

>>> hdl/ctu_pre.sv
module ctu_pre import ctu_pkg::*; #(
  parameter int unsigned ITERATIONS = CTU_ITERATIONS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ctu_word_t          word_o
);

  localparam logic signed [16:0] Range = 17'(ctu_range(ITERATIONS));
  localparam logic signed [16:0] One   = 17'sd16384;

  logic              valid_q;
  ctu_word_t         word_q, word_d;
  logic signed [16:0] a_ext, p, ap_full;
  logic [29:0]       sq;
  logic              out_of_range;

  always_comb begin
    a_ext        = 17'(a_i);
    out_of_range = (a_ext > One) || (a_ext < -One);
    if (a_ext > One) begin
      p = One;
    end else if (a_ext < -One) begin
      p = -One;
    end else begin
      p = a_ext;
    end
    ap_full = p[16] ? -p : p;
    sq      = 30'(ap_full[14:0]) * 30'(ap_full[14:0]);

    word_d      = '0;
    word_d.mode = ctu_mode_e'(mode_i);
    word_d.a    = a_i;
    word_d.b    = b_i;
    word_d.ap   = ap_full[14:0];
    word_d.neg  = p[16];
    word_d.r    = sq;
    word_d.q    = '0;
    unique case (ctu_mode_e'(mode_i))
      CTU_SINCOS: word_d.err = (a_ext > Range) || (a_ext < -Range);
      CTU_ATAN:   word_d.err = a_i[15];
      CTU_ACOS:   word_d.err = out_of_range;
      default:    word_d.err = 1'b1;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> hdl/ctu_sqrt_stage.sv
module ctu_sqrt_stage import ctu_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  ctu_word_t word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output ctu_word_t word_o
);

  // trial bit of this step, 2^(28 - 2K)
  localparam logic [CTU_RW-1:0] Bit = CTU_RW'(1) << (28 - 2 * K);

  logic              valid_q;
  ctu_word_t         word_q, word_d;
  logic [CTU_RW-1:0] rin, t, qs;

  always_comb begin
    if (K == 0) begin
      // radicand (1 - p^2) in Q28, the square arrives in r
      rin = (CTU_RW'(16384) - CTU_RW'(word_i.r[CTU_RW-1:14])) << 14;
    end else begin
      rin = word_i.r;
    end
    t      = word_i.q + Bit;
    qs     = word_i.q >> 1;
    word_d = word_i;
    if (rin >= t) begin
      word_d.r = rin - t;
      word_d.q = qs + Bit;
    end else begin
      word_d.r = rin;
      word_d.q = qs;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> hdl/ctu_cordic_stage.sv
module ctu_cordic_stage import ctu_pkg::*; #(
  parameter int unsigned I = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  ctu_word_t word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output ctu_word_t word_o
);

  localparam logic signed [CTU_ZW-1:0] Step = CTU_ZW'(ctu_atan(I));

  logic                     valid_q;
  ctu_word_t                word_q, word_d;
  logic signed [CTU_XW-1:0] x, y, xs, ys;
  logic signed [CTU_ZW-1:0] z;
  logic                     sub;

  always_comb begin
    if (I == 0) begin
      // load the start vector for the mode
      unique case (word_i.mode)
        CTU_SINCOS: begin
          x = CTU_ONE;
          y = '0;
          z = CTU_ZW'(word_i.a);
        end
        CTU_ATAN: begin
          x = CTU_XW'(word_i.a);
          y = CTU_XW'(word_i.b);
          z = '0;
        end
        CTU_ACOS: begin
          x = CTU_XW'({1'b0, word_i.ap});
          y = CTU_XW'({1'b0, word_i.q[14:0]});
          z = '0;
        end
        default: begin
          x = '0;
          y = '0;
          z = '0;
        end
      endcase
    end else begin
      x = word_i.x;
      y = word_i.y;
      z = word_i.z;
    end
    xs = x >>> I;
    ys = y >>> I;
    // rotation steers z to zero, vectoring steers y to zero
    sub    = (word_i.mode == CTU_SINCOS) ? !z[CTU_ZW-1] : y[CTU_XW-1];
    word_d = word_i;
    if (sub) begin
      word_d.x = x - ys;
      word_d.y = y + xs;
      word_d.z = z - Step;
    end else begin
      word_d.x = x + ys;
      word_d.y = y - xs;
      word_d.z = z + Step;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> hdl/ctu_post.sv
module ctu_post import ctu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ctu_word_t          word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [16:0] res0_o,
  output logic signed [15:0] res1_o,
  output logic               err_o
);

  localparam logic signed [CTU_GW-1:0] Max0 = 20'sd65535;
  localparam logic signed [CTU_GW-1:0] Min0 = -20'sd65536;
  localparam logic signed [CTU_GW-1:0] Max1 = 20'sd32767;
  localparam logic signed [CTU_GW-1:0] Min1 = -20'sd32768;

  // gain stage
  logic               g_valid_q, g_ready;
  ctu_res_t           g_q, g_d;
  logic signed [33:0] px, py, gain;

  assign gain = 34'(signed'({1'b0, CTU_GAIN}));

  always_comb begin
    px      = 34'(word_i.x) * gain;
    py      = 34'(word_i.y) * gain;
    g_d     = '0;
    g_d.mode = word_i.mode;
    g_d.neg  = word_i.neg;
    g_d.err  = word_i.err;
    g_d.gx   = px[33:14];
    g_d.gy   = py[33:14];
    g_d.z    = word_i.z;
  end

  assign ready_o = !g_valid_q || g_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (ready_o) begin
      g_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      g_q <= g_d;
    end
  end

  // select, reflect and saturate into the output register
  logic                     o_valid_q;
  logic signed [16:0]       res0_q, res0_d;
  logic signed [15:0]       res1_q, res1_d;
  logic                     err_q;
  logic signed [CTU_GW-1:0] r0, r1, zx;

  always_comb begin
    zx = CTU_GW'(g_q.z);
    unique case (g_q.mode)
      CTU_SINCOS: r0 = g_q.gx;
      CTU_ATAN:   r0 = zx;
      CTU_ACOS:   r0 = g_q.neg ? (CTU_PI - zx) : zx;
      default:    r0 = '0;
    endcase
    r1 = (g_q.mode == CTU_SINCOS) ? g_q.gy : '0;
    if (r0 > Max0) begin
      res0_d = 17'sd65535;
    end else if (r0 < Min0) begin
      res0_d = -17'sd65536;
    end else begin
      res0_d = r0[16:0];
    end
    if (r1 > Max1) begin
      res1_d = 16'sd32767;
    end else if (r1 < Min1) begin
      res1_d = -16'sd32768;
    end else begin
      res1_d = r1[15:0];
    end
  end

  assign g_ready = !o_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (g_ready) begin
      o_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_ready && g_valid_q) begin
      res0_q <= res0_d;
      res1_q <= res1_d;
      err_q  <= g_q.err;
    end
  end

  assign valid_o = o_valid_q;
  assign res0_o  = res0_q;
  assign res1_o  = res1_q;
  assign err_o   = err_q;

endmodule

>>> hdl/cordic_trig_unit.sv
// Every stage is its own register: input, root and CORDIC steps, gain and output.
// Throughput: one word per cycle in every mode while out_o is not stalled.
// The 15-step square root pipe and the ITERATIONS CORDIC stages set the depth.
// A stalled output holds; bubbles in the pipe close up behind it.
// Reset (rst_ni low, asynchronous) clears all valid bits; no data is flushed.
module cordic_trig_unit import ctu_pkg::*; #(
  parameter int unsigned ITERATIONS = CTU_ITERATIONS
) (
  input  logic clk_i,
  input  logic rst_ni,
  ctu_in_if.sink    in_i,
  ctu_out_if.source out_o
);

  localparam int unsigned NS    = CTU_SQRT_STEPS;
  localparam int unsigned NODES = NS + ITERATIONS + 1;

  // node 0: square stage, nodes 1..NS: root steps, then CORDIC steps
  logic      valid [NODES];
  logic      ready [NODES];
  ctu_word_t word  [NODES];

  ctu_pre #(
    .ITERATIONS(ITERATIONS)
  ) u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .mode_i  (in_i.mode),
    .a_i     (in_i.first_operand),
    .b_i     (in_i.second_operand),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .word_o  (word[0])
  );

  // integer square root for the arccosine, one result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    ctu_sqrt_stage #(
      .K(k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .word_i  (word[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .word_o  (word[k+1])
    );
  end

  // CORDIC micro-rotations; the first stage loads the start vector
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cordic
    ctu_cordic_stage #(
      .I(i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[NS+i]),
      .ready_o (ready[NS+i]),
      .word_i  (word[NS+i]),
      .valid_o (valid[NS+i+1]),
      .ready_i (ready[NS+i+1]),
      .word_o  (word[NS+i+1])
    );
  end

  // gain correction, pi reflection, saturation and the output register
  ctu_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NODES-1]),
    .ready_o (ready[NODES-1]),
    .word_i  (word[NODES-1]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res0_o  (out_o.angle_or_cosine),
    .res1_o  (out_o.sine_value),
    .err_o   (out_o.domain_error)
  );

endmodule
